// ===== sv/okl_pkg.sv =====
// shared types and constants for the opposing key last-input resolver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package okl_pkg;

	localparam int KEY_W         = 8;
	localparam int NUM_REGS      = 8;
	localparam int REG_IDX_W     = $clog2(NUM_REGS);
	localparam int MAX_PAIRS     = NUM_REGS / 2;
	localparam int NUM_PAIRS_DEF = 4;
	localparam int IN_TDATA_W    = 8;
	localparam int IN_TUSER_W    = 2;
	localparam int OUT_TDATA_W   = 16;

	// default pairs: 'A'/'D' and 'W'/'S', the rest disabled
	localparam logic [KEY_W-1:0] PAIR_KEY_RST [NUM_REGS] = '{
		8'd65, 8'd68, 8'd87, 8'd83, 8'd0, 8'd0, 8'd0, 8'd0
	};

	typedef enum logic [1:0] {
		ST_RELEASED = 2'd0,
		ST_ACTIVE   = 2'd1,
		ST_NULLED   = 2'd2
	} status_t;

	typedef struct packed {
		logic             inject_release;
		logic [KEY_W-1:0] inject_key;
		logic             inject_valid;
		logic             pass_event;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/okl_resolve.sv =====
// per-event resolve logic: home slot match, opposite lookup, status update
// depends on okl_pkg
`timescale 1ns / 1ps
`default_nettype none

module okl_resolve
	import okl_pkg::*;
#(
	parameter int NUM_PAIRS = NUM_PAIRS_DEF
) (
	input  wire logic [KEY_W-1:0] slot_key [2*NUM_PAIRS],
	input  wire status_t          status [2*NUM_PAIRS],
	input  wire logic [KEY_W-1:0] key_code,
	input  wire logic             is_release,
	input  wire logic             self_injected,
	output status_t               status_nxt [2*NUM_PAIRS],
	output result_t               result
);

	localparam int NSLOT  = 2 * NUM_PAIRS;
	localparam int SLOT_W = $clog2(NSLOT);

	logic              en [NSLOT];
	logic              h_found;
	logic [SLOT_W-1:0] h_idx;
	logic [SLOT_W-1:0] os_idx;
	logic [KEY_W-1:0]  opp_key;
	status_t           st_h;
	status_t           new_h;
	status_t           st_os;

	always_comb begin
		for (int s = 0; s < NSLOT; s++) begin
			en[s] = (slot_key[s & ~1] != '0) && (slot_key[s | 1] != '0);
		end
	end

	// highest enabled slot holding the event's key
	always_comb begin
		h_found = 1'b0;
		h_idx   = '0;
		for (int s = 0; s < NSLOT; s++) begin
			if (key_code != '0 && en[s] && slot_key[s] == key_code) begin
				h_found = 1'b1;
				h_idx   = SLOT_W'(s);
			end
		end
	end

	assign opp_key = slot_key[h_idx ^ SLOT_W'(1)];

	// the opposite key's own home slot, which may sit in a later pair
	always_comb begin
		os_idx = h_idx ^ SLOT_W'(1);
		for (int s = 0; s < NSLOT; s++) begin
			if (en[s] && slot_key[s] == opp_key) begin
				os_idx = SLOT_W'(s);
			end
		end
	end

	assign st_h  = status[h_idx];
	assign new_h = is_release ? ST_RELEASED : ST_ACTIVE;
	// a key paired with itself sees its own fresh status
	assign st_os = (os_idx == h_idx) ? new_h : status[os_idx];

	always_comb begin
		status_nxt            = status;
		result.pass_event     = 1'b1;
		result.inject_valid   = 1'b0;
		result.inject_key     = '0;
		result.inject_release = 1'b0;
		if (h_found && !self_injected) begin
			if (!is_release && st_h != ST_RELEASED) begin
				// repeated press: swallowed only while nulled
				result.pass_event = (st_h != ST_NULLED);
			end else begin
				status_nxt[h_idx] = new_h;
				if (st_os == (is_release ? ST_NULLED : ST_ACTIVE)) begin
					status_nxt[os_idx]    = is_release ? ST_ACTIVE : ST_NULLED;
					result.inject_valid   = 1'b1;
					result.inject_key     = opp_key;
					result.inject_release = !is_release;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/opposing_key_last_input_resolver.sv =====
// Opposing key resolver with last-input priority. Key events enter on the s_ stream
// (tdata = key code, tuser bit 0 = release, bit 1 = self injected) and one result per
// event leaves on the m_ stream. One event is taken every clock cycle while the m_ side
// keeps taking results. The input register loads at the event's transfer and the result
// register when the event advances, which waits while a held result is not yet taken.
// The key status is updated in the same cycle the result is registered, so back-to-back
// events on the same pair resolve in order. The user must write the pair keys through
// the cfg_ port only while no event is in flight; the block itself does not enforce it.
// depends on okl_pkg and okl_resolve
`timescale 1ns / 1ps
`default_nettype none

module opposing_key_last_input_resolver
	import okl_pkg::*;
#(
	parameter int NUM_PAIRS = NUM_PAIRS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [REG_IDX_W-1:0]   cfg_addr,
	input  wire logic [KEY_W-1:0]       cfg_wdata,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // [7:0] key_code
	input  wire logic [IN_TUSER_W-1:0]  s_tuser,  // [0] is_release, [1] self_injected
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata   // [0] pass_event, [1] inject_valid,
	                                              // [9:2] inject_key, [10] inject_release
);

	localparam int NSLOT = 2 * NUM_PAIRS;

	logic [KEY_W-1:0] pair_key_q [NUM_REGS];
	logic [KEY_W-1:0] slot_key [NSLOT];
	status_t          status_q [NSLOT];
	status_t          status_nxt [NSLOT];

	logic             vld_s1;
	logic [KEY_W-1:0] key_s1;
	logic             rel_s1;
	logic             self_s1;

	logic             out_vld_q;
	result_t          result_q;
	result_t          result;
	logic             advance;

	assign advance  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;

	always_comb begin
		for (int s = 0; s < NSLOT; s++) begin
			slot_key[s] = pair_key_q[s];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_key_q <= PAIR_KEY_RST;
		end else if (cfg_we) begin
			pair_key_q[cfg_addr] <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			key_s1  <= s_tdata[KEY_W-1:0];
			rel_s1  <= s_tuser[0];
			self_s1 <= s_tuser[1];
		end
	end

	okl_resolve #(
		.NUM_PAIRS(NUM_PAIRS)
	) u_resolve (
		.slot_key     (slot_key),
		.status       (status_q),
		.key_code     (key_s1),
		.is_release   (rel_s1),
		.self_injected(self_s1),
		.status_nxt   (status_nxt),
		.result       (result)
	);

	// status and result register move together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			for (int s = 0; s < NSLOT; s++) begin
				status_q[s] <= ST_RELEASED;
			end
		end else begin
			if (advance) begin
				out_vld_q <= 1'b1;
				status_q  <= status_nxt;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), result_q};

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the opposing key last-input resolver: streams key events
// with random gaps and stalls, predicts each result and compares it field by field
// depends on okl_pkg and the resolver rtl
`timescale 1ns / 1ps

module testbench;
	import okl_pkg::*;

	localparam int NUM_PAIRS = NUM_PAIRS_DEF;
	localparam int RES_W     = $bits(result_t);

	typedef logic [KEY_W-1:0] pair_keys_t [NUM_REGS];

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0]   cfg_addr  = '0;
	logic [KEY_W-1:0]       cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;  // [7:0] key_code
	logic [IN_TUSER_W-1:0]  s_tuser   = '0;  // [0] is_release, [1] self_injected
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // [0] pass_event, [1] inject_valid,
	                                         // [9:2] inject_key, [10] inject_release

	opposing_key_last_input_resolver #(
		.NUM_PAIRS(NUM_PAIRS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// predictor copy of the pair registers and key status
	logic [KEY_W-1:0] pair_key_q [NUM_REGS];
	status_t          key_st     [NUM_REGS];
	result_t          expected_results [$];
	int               errors        = 0;
	int               tx_burst      = 0;
	int               rx_burst      = 0;
	int               rx_hold_cycles = 0;

	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			burst = $urandom_range(10, 30);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	// highest enabled slot that holds the key, -1 if none
	function automatic int find_home(logic [KEY_W-1:0] k);
		int found;
		found = -1;
		if (k == 0)
			return -1;
		for (int s = 0; s < 2 * NUM_PAIRS; s++) begin
			if (pair_key_q[s & ~1] != 0 && pair_key_q[s | 1] != 0 && pair_key_q[s] == k)
				found = s;
		end
		return found;
	endfunction

	function automatic result_t resolve_event(logic [KEY_W-1:0] k, logic rel, logic self_inj);
		result_t          r;
		int               h;
		int               os;
		logic [KEY_W-1:0] opp;
		r = '0;
		r.pass_event = 1'b1;
		h = find_home(k);
		if (h < 0 || self_inj)
			return r;
		opp = pair_key_q[h ^ 1];
		os = find_home(opp);
		if (os < 0)
			os = h ^ 1;
		// repeated press: a nulled key stays suppressed, an active one passes
		if (!rel && key_st[h] != ST_RELEASED) begin
			r.pass_event = (key_st[h] == ST_NULLED) ? 1'b0 : 1'b1;
			return r;
		end
		key_st[h] = rel ? ST_RELEASED : ST_ACTIVE;
		if (key_st[os] == (rel ? ST_NULLED : ST_ACTIVE)) begin
			key_st[os] = rel ? ST_ACTIVE : ST_NULLED;
			r.inject_valid   = 1'b1;
			r.inject_key     = opp;
			r.inject_release = !rel;
		end
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return pair_key_q[$urandom_range(0, NUM_REGS - 1)];
		if (r < 17)
			return KEY_W'($urandom_range(1, 8));
		return KEY_W'($urandom_range(0, 255));
	endfunction

	task automatic send_event(logic [KEY_W-1:0] k, logic rel, logic self_inj);
		int w;
		w = draw_wait(tx_burst);
		// valid is only lowered when a gap follows, never dropped and raised in one step
		if (w > 0) begin
			s_tvalid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= k;
		s_tuser  <= {self_inj, rel};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(resolve_event(k, rel, self_inj));
	endtask

	task automatic send_random(int n);
		for (int i = 0; i < n; i++)
			send_event(pick_key(), 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_pairs(pair_keys_t keys);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= REG_IDX_W'(i);
			cfg_wdata <= keys[i];
			@(posedge clk);
			pair_key_q[i] = keys[i];
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_pairs();
		pair_keys_t keys;
		for (int i = 0; i < NUM_REGS; i++) begin
			case ($urandom_range(0, 7))
				0: keys[i] = '0;
				1: keys[i] = '1;
				default: keys[i] = KEY_W'($urandom_range(1, 6));
			endcase
		end
		write_pairs(keys);
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[RES_W-1:0]);
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer, m_tdata %h", m_tdata);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("pass_event", want.pass_event, got.pass_event);
				check_field("inject_valid", want.inject_valid, got.inject_valid);
				check_field("inject_key", want.inject_key, got.inject_key);
				check_field("inject_release", want.inject_release, got.inject_release);
				check_field("tdata_pad", 0, m_tdata[OUT_TDATA_W-1:RES_W]);
			end
		end
	end

	// result receiver with random stalls and an optional long hold-off
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			if (rx_hold_cycles > 0) begin
				w = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				w = draw_wait(rx_burst);
			end
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic test_default_pairs();
		localparam logic [KEY_W-1:0] KA = "A", KD = "D", KW = "W", KS = "S";
		send_event(KA, 1'b0, 1'b0);
		send_event(KD, 1'b0, 1'b0);   // nulls A, injects its release
		send_event(KA, 1'b0, 1'b0);   // press of a nulled key is suppressed
		send_event(KD, 1'b1, 1'b0);   // A comes back with an injected press
		send_event(KA, 1'b1, 1'b0);
		send_event(KW, 1'b0, 1'b0);
		send_event(KS, 1'b0, 1'b0);
		send_event(KW, 1'b1, 1'b0);   // release of the nulled key
		send_event(KS, 1'b1, 1'b0);
		send_event(KS, 1'b0, 1'b0);
		send_event(KS, 1'b0, 1'b0);   // repeated press of an active key
		send_event(KW, 1'b0, 1'b0);
		send_event(KS, 1'b1, 1'b0);
		send_event(KW, 1'b1, 1'b0);
		send_event(KA, 1'b0, 1'b1);   // self injected events pass untouched
		send_event(KD, 1'b0, 1'b1);
		send_event(KD, 1'b1, 1'b1);
		send_event(8'd0, 1'b0, 1'b0);
		send_event(8'd0, 1'b1, 1'b0);
		send_event(8'hFF, 1'b0, 1'b0);
		send_event(8'hFF, 1'b1, 1'b1);
		send_event(KA, 1'b1, 1'b0);   // release of a released key
		send_event("a", 1'b0, 1'b0);
	endtask

	task automatic test_shared_keys();
		wait_idle();
		// 20 and 10 sit in two pairs, pair 2 is disabled by its zero key
		write_pairs(pair_keys_t'{8'd10, 8'd20, 8'd20, 8'd30, 8'd40, 8'd0, 8'd10, 8'd50});
		send_random(80);
	endtask

	task automatic test_self_and_extreme_pairs();
		wait_idle();
		write_pairs(pair_keys_t'{8'd255, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127, 8'd0, 8'd0});
		send_random(80);
	endtask

	task automatic test_input_stall();
		wait_idle();
		random_pairs();
		tx_burst = 60;
		rx_hold_cycles = 300;
		send_random(60);
	endtask

	task automatic test_random_pairs();
		repeat (5) begin
			wait_idle();
			random_pairs();
			send_random(60);
		end
	endtask

	task automatic test_disabled_pairs();
		wait_idle();
		write_pairs(pair_keys_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
		send_random(20);
	endtask

	initial begin
		for (int i = 0; i < NUM_REGS; i++) begin
			pair_key_q[i] = PAIR_KEY_RST[i];
			key_st[i]     = ST_RELEASED;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_pairs();
		test_shared_keys();
		test_self_and_extreme_pairs();
		test_input_stall();
		test_random_pairs();
		test_disabled_pairs();
		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#1000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
